[rtl/bmpsc_pkg.sv]
// Shared constants and types for the BMP nearest-neighbor scaler front end.
package bmpsc_pkg;

    localparam logic [15:0] BMP_MAGIC      = 16'h4D42;
    localparam logic [31:0] BMP_MIN_OFFSET = 32'd54;

    localparam int SRC_W_W    = 12;  // source width register
    localparam int SRC_H_W    = 13;  // signed source height register
    localparam int DEPTH_W    = 6;   // bits per pixel register
    localparam int DIM_W      = 12;  // destination size registers
    localparam int STRIDE_W   = 15;  // padded row stride in bytes
    localparam int PIXB_W     = 14;  // column byte offset
    localparam int ROWOFF_W   = 27;  // row * stride
    localparam int RGB_W      = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // quotient is always below the source size, so 12 bits suffice
    localparam int QUO_W      = 12;
    localparam int DIV_STEPS  = 2;                    // quotient bits per stage
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;
    localparam int PIPE_DEPTH = DIV_STAGES + 3;       // entry, divide, row, output

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAGIC       = 3'd0,
        REG_DATA_OFFSET = 3'd1,
        REG_SRC_WIDTH   = 3'd2,
        REG_SRC_HEIGHT  = 3'd3,
        REG_BIT_DEPTH   = 3'd4,
        REG_DST_WIDTH   = 3'd5,
        REG_DST_HEIGHT  = 3'd6
    } cfg_reg_t;

    // per-request control that rides alongside the divider lanes
    typedef struct packed {
        logic             kind;
        logic             clamp_x;
        logic             clamp_y;
        logic             no_div;
        logic [RGB_W-1:0] rgb;
    } side_t;

endpackage

[rtl/bmpsc_if.sv]
// Request, response and configuration channel interfaces.
interface bmpsc_in_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [COORD_BITS-1:0] dest_x;
    logic [COORD_BITS-1:0] dest_y;
    logic [7:0]            blue_byte;
    logic [7:0]            green_byte;
    logic [7:0]            red_byte;

    modport source (output valid, kind, dest_x, dest_y, blue_byte, green_byte, red_byte,
                    input ready);
    modport sink   (input valid, kind, dest_x, dest_y, blue_byte, green_byte, red_byte,
                    output ready);
endinterface

interface bmpsc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] source_byte_offset;
    logic [15:0] pixel_rgb565;
    logic        header_ok;

    modport source (output valid, source_byte_offset, pixel_rgb565, header_ok,
                    input ready);
    modport sink   (input valid, source_byte_offset, pixel_rgb565, header_ok,
                    output ready);
endinterface

interface bmpsc_cfg_if;
    import bmpsc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/bmpsc_div_lane.sv]
// Pipelined restoring divider lane, DIV_STEPS quotient bits per stage.
module bmpsc_div_lane #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 12
) (
    input  logic                            clk,
    input  logic [bmpsc_pkg::DIV_STAGES-1:0] en,
    input  logic [NUM_W-1:0]                num,
    input  logic [DEN_W-1:0]                den,
    output logic [bmpsc_pkg::QUO_W-1:0]     quo
);
    import bmpsc_pkg::*;

    // the last stage's remainder is not needed
    logic [NUM_W-1:0] rem_reg [DIV_STAGES-1];
    logic [QUO_W-1:0] quo_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [NUM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (s == 0) begin : g_first
            assign rem_in = num;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        always_comb
        begin
            logic [NUM_W-1:0] r;
            logic [NUM_W-1:0] t;
            logic [QUO_W-1:0] q;
            r = rem_in;
            q = quo_in;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                t = NUM_W'(den) << (QUO_W - 1 - s * DIV_STEPS - k);
                if (r >= t)
                begin
                    r = r - t;
                    q[QUO_W - 1 - s * DIV_STEPS - k] = 1'b1;
                end
            end
            rem_next = r;
            quo_next = q;
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                quo_reg[s] <= quo_next;
            end
        end

        if (s < DIV_STAGES - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    rem_reg[s] <= rem_next;
                end
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

[rtl/bmp_nearest_scale_rgb565.sv]
// Top level: BMP header registers, source address pipeline and RGB565 packing.
// Path: entry register, divider stages, row register, then the response register.
// Throughput: one request per cycle; every stage holds under backpressure and
//   ready follows the stage occupancy back from the response ready.
// The depth is set by the two 12-bit divider lanes, 2 quotient bits per stage.
// Reset: rst_n (async, low) empties the pipeline and loads the header
//   registers with 0x4D42, 54, 800, 480, 24, 800 and 480.
module bmp_nearest_scale_rgb565 #(
    parameter int COORD_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    bmpsc_in_if.sink    req,
    bmpsc_out_if.source rsp,
    bmpsc_cfg_if.sink   cfg
);
    import bmpsc_pkg::*;

    localparam int NY_W   = COORD_BITS + SRC_H_W;   // dest_y * |height|
    localparam int NX_W   = COORD_BITS + SRC_W_W;   // dest_x * width
    localparam int ST_ROW = DIV_STAGES + 1;         // row / column stage
    localparam int ST_OUT = DIV_STAGES + 2;         // response register

    // ------------------------------------------------------------------
    // Header registers. The user must write them only while the pipeline
    // is empty (the block does not enforce this), so every stage reads them directly.
    // ------------------------------------------------------------------
    logic [15:0]           magic_reg;
    logic [31:0]           data_offset_reg;
    logic [SRC_W_W-1:0]    src_width_reg;
    logic [SRC_H_W-1:0]    src_height_reg;
    logic [DEPTH_W-1:0]    bit_depth_reg;
    logic [DIM_W-1:0]      dst_width_reg;
    logic [DIM_W-1:0]      dst_height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg       <= BMP_MAGIC;
            data_offset_reg <= BMP_MIN_OFFSET;
            src_width_reg   <= SRC_W_W'(800);
            src_height_reg  <= SRC_H_W'(480);
            bit_depth_reg   <= DEPTH_W'(24);
            dst_width_reg   <= DIM_W'(800);
            dst_height_reg  <= DIM_W'(480);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_MAGIC:       magic_reg       <= cfg.data[15:0];
                REG_DATA_OFFSET: data_offset_reg <= cfg.data;
                REG_SRC_WIDTH:   src_width_reg   <= cfg.data[SRC_W_W-1:0];
                REG_SRC_HEIGHT:  src_height_reg  <= cfg.data[SRC_H_W-1:0];
                REG_BIT_DEPTH:   bit_depth_reg   <= cfg.data[DEPTH_W-1:0];
                REG_DST_WIDTH:   dst_width_reg   <= cfg.data[DIM_W-1:0];
                REG_DST_HEIGHT:  dst_height_reg  <= cfg.data[DIM_W-1:0];
                default:         ;  // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Header-derived values
    // ------------------------------------------------------------------
    logic [SRC_H_W-1:0]    abs_h;       // 1..4096 when the header is valid
    logic [QUO_W-1:0]      abs_h_m1;
    logic [QUO_W-1:0]      src_w_m1;
    logic                  top_down;
    logic                  bpp4;
    logic [PIXB_W-1:0]     row_bytes;
    logic [STRIDE_W-1:0]   stride;
    logic [COORD_BITS-1:0] dw;
    logic [COORD_BITS-1:0] dh;
    logic                  hdr_ok;

    assign top_down  = src_height_reg[SRC_H_W-1];
    assign abs_h     = top_down ? (~src_height_reg + SRC_H_W'(1)) : src_height_reg;
    assign abs_h_m1  = QUO_W'(abs_h - SRC_H_W'(1));
    assign src_w_m1  = QUO_W'(src_width_reg - SRC_W_W'(1));
    assign bpp4      = (bit_depth_reg == DEPTH_W'(32));
    assign row_bytes = bpp4 ? {src_width_reg, 2'b00}
                            : (PIXB_W'(src_width_reg) + PIXB_W'({src_width_reg, 1'b0}));
    // rows are padded to a multiple of four bytes
    assign stride    = (STRIDE_W'(row_bytes) + STRIDE_W'(3)) & ~STRIDE_W'(3);
    assign dw        = COORD_BITS'(dst_width_reg);
    assign dh        = COORD_BITS'(dst_height_reg);
    assign hdr_ok    = (magic_reg == BMP_MAGIC)
                    && (bit_depth_reg == DEPTH_W'(24) || bit_depth_reg == DEPTH_W'(32))
                    && (src_width_reg != '0)
                    && (src_height_reg != '0)
                    && (data_offset_reg >= BMP_MIN_OFFSET);

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage may load when it is empty or when
    // its content moves on in the same cycle.
    // ------------------------------------------------------------------
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH-1:0] free;

    always_comb
    begin
        free[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || rsp.ready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--)
        begin
            free[i] = !valid_reg[i] || free[i+1];
        end
        valid_next[0] = free[0] ? req.valid : valid_reg[0];
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            valid_next[i] = free[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign req.ready = free[0];

    // ------------------------------------------------------------------
    // Stage 0: products for both axes, clamp flags, color packing.
    // dest >= dest size means the quotient would reach the source size,
    // so the clamp is decided here and the divider only needs 12 bits.
    // ------------------------------------------------------------------
    side_t            side_reg [DIV_STAGES+1];
    logic [NY_W-1:0]  num_y_reg;
    logic [NX_W-1:0]  num_x_reg;
    side_t            side_in;

    always_comb
    begin
        side_in.kind    = req.kind;
        side_in.clamp_x = (req.dest_x >= dw);
        side_in.clamp_y = (req.dest_y >= dh);
        side_in.no_div  = (dw == '0) || (dh == '0);
        side_in.rgb     = {req.red_byte[7:3], req.green_byte[7:2], req.blue_byte[7:3]};
    end

    always_ff @(posedge clk)
    begin
        if (free[0])
        begin
            side_reg[0] <= side_in;
            num_y_reg   <= NY_W'(req.dest_y) * NY_W'(abs_h);
            num_x_reg   <= NX_W'(req.dest_x) * NX_W'(src_width_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stages 1..DIV_STAGES: divider lanes, control rides alongside
    // ------------------------------------------------------------------
    logic [QUO_W-1:0] quo_y;
    logic [QUO_W-1:0] quo_x;

    bmpsc_div_lane #(
        .NUM_W (NY_W),
        .DEN_W (COORD_BITS)
    ) u_div_y (
        .clk (clk),
        .en  (free[DIV_STAGES:1]),
        .num (num_y_reg),
        .den (dh),
        .quo (quo_y)
    );

    bmpsc_div_lane #(
        .NUM_W (NX_W),
        .DEN_W (COORD_BITS)
    ) u_div_x (
        .clk (clk),
        .en  (free[DIV_STAGES:1]),
        .num (num_x_reg),
        .den (dw),
        .quo (quo_x)
    );

    for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_side
        always_ff @(posedge clk)
        begin
            if (free[s])
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Row stage: clamp, flip for bottom-up files, row * stride product
    // ------------------------------------------------------------------
    side_t               side_row_reg;
    logic [ROWOFF_W-1:0] row_off_reg;
    logic [PIXB_W-1:0]   col_off_reg;
    logic [QUO_W-1:0]    src_y;
    logic [QUO_W-1:0]    src_x;
    logic [QUO_W-1:0]    row;
    logic [PIXB_W-1:0]   col_off;

    assign src_y   = side_reg[DIV_STAGES].clamp_y ? abs_h_m1 : quo_y;
    assign src_x   = side_reg[DIV_STAGES].clamp_x ? src_w_m1 : quo_x;
    assign row     = top_down ? src_y : (abs_h_m1 - src_y);
    assign col_off = bpp4 ? {src_x, 2'b00}
                          : (PIXB_W'(src_x) + PIXB_W'({src_x, 1'b0}));

    always_ff @(posedge clk)
    begin
        if (free[ST_ROW])
        begin
            side_row_reg <= side_reg[DIV_STAGES];
            row_off_reg  <= ROWOFF_W'(row) * ROWOFF_W'(stride);
            col_off_reg  <= col_off;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: address sum wraps at 32 bits; unused field is zero
    // ------------------------------------------------------------------
    logic [31:0] offset_reg;
    logic [15:0] rgb_reg;
    logic        ok_reg;
    logic [31:0] addr_sum;

    assign addr_sum = data_offset_reg + 32'(row_off_reg) + 32'(col_off_reg);

    always_ff @(posedge clk)
    begin
        if (free[ST_OUT])
        begin
            offset_reg <= (!side_row_reg.kind && hdr_ok && !side_row_reg.no_div)
                          ? addr_sum : 32'd0;
            rgb_reg    <= side_row_reg.kind ? side_row_reg.rgb : 16'd0;
            ok_reg     <= hdr_ok;
        end
    end

    assign rsp.valid              = valid_reg[ST_OUT];
    assign rsp.source_byte_offset = offset_reg;
    assign rsp.pixel_rgb565       = rgb_reg;
    assign rsp.header_ok          = ok_reg;

endmodule

[rtl/bmpsc_check.sv]
// Port-level checker for the scaler front end, bound to the top level.
module bmpsc_check (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_offset,
    input logic [15:0] rsp_rgb,
    input logic        rsp_ok
);
    import bmpsc_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

    logic [CNT_W-1:0] pending_reg;
    logic [CNT_W-1:0] pending_next;

    always_comb
    begin
        pending_next = pending_reg + CNT_W'(req_valid && req_ready)
                                   - CNT_W'(rsp_valid && rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_offset)
                                    && $stable(rsp_rgb) && $stable(rsp_ok))
        else $error("response changed while stalled");

    a_bad_header: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> rsp_offset == 32'd0)
        else $error("address given with invalid header");

    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_rgb != 16'd0 |-> rsp_offset == 32'd0)
        else $error("color and address in the same response");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != '0)
        else $error("response without a pending request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more requests in flight than pipeline stages");

endmodule

bind bmp_nearest_scale_rgb565 bmpsc_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_offset (rsp.source_byte_offset),
    .rsp_rgb    (rsp.pixel_rgb565),
    .rsp_ok     (rsp.header_ok)
);

[verif/bmpsc_checker.sv]
// Response checker: tracks header register writes, predicts each response, compares.
`timescale 1ns / 100ps

module bmpsc_checker
    import bmpsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bmpsc_in_if  req,
    bmpsc_out_if rsp,
    bmpsc_cfg_if cfg,
    output int   mismatch_cnt,
    output int   in_flight
);

    typedef struct packed {
        logic [31:0] src_offset;
        logic [15:0] rgb565;
        logic        hdr_ok;
    } lookup_t;

    // shadow of the header registers
    logic [15:0] hdr_magic;
    logic [31:0] hdr_offset;
    logic [11:0] hdr_src_w;
    logic [12:0] hdr_src_h;
    logic [5:0]  hdr_depth;
    logic [11:0] hdr_dst_w;
    logic [11:0] hdr_dst_h;

    lookup_t lookups_in_flight[$];
    lookup_t want;
    lookup_t got;

    function automatic void store_header_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        case (cfg_reg_t'(idx))
            REG_MAGIC:       hdr_magic  = val[15:0];
            REG_DATA_OFFSET: hdr_offset = val;
            REG_SRC_WIDTH:   hdr_src_w  = val[11:0];
            REG_SRC_HEIGHT:  hdr_src_h  = val[12:0];
            REG_BIT_DEPTH:   hdr_depth  = val[5:0];
            REG_DST_WIDTH:   hdr_dst_w  = val[11:0];
            REG_DST_HEIGHT:  hdr_dst_h  = val[11:0];
            default:         ;  // unmapped index, dropped
        endcase
    endfunction

    function automatic logic header_good();
        return hdr_magic == BMP_MAGIC && (hdr_depth == 6'd24 || hdr_depth == 6'd32) &&
               hdr_src_w != '0 && hdr_src_h != '0 && hdr_offset >= BMP_MIN_OFFSET;
    endfunction

    // file offset of the blue byte of the nearest source pixel
    function automatic logic [31:0] source_address(logic [11:0] dx, logic [11:0] dy);
        logic [63:0] abs_h;
        logic [63:0] bpp;
        logic [63:0] sx;
        logic [63:0] sy;
        logic [63:0] row;
        logic [63:0] stride;
        logic [63:0] sum;
        abs_h = hdr_src_h[12] ? 64'd8192 - 64'(hdr_src_h) : 64'(hdr_src_h);
        bpp   = 64'(hdr_depth >> 3);
        if (hdr_dst_w == '0 || hdr_dst_h == '0)
            return '0;
        sy = (64'(dy) * abs_h) / 64'(hdr_dst_h);
        sx = (64'(dx) * 64'(hdr_src_w)) / 64'(hdr_dst_w);
        if (sy > abs_h - 1)
            sy = abs_h - 1;
        if (sx > 64'(hdr_src_w) - 1)
            sx = 64'(hdr_src_w) - 1;
        row    = hdr_src_h[12] ? sy : abs_h - 1 - sy;
        stride = (64'(hdr_src_w) * bpp + 64'd3) & ~64'd3;
        sum    = 64'(hdr_offset) + row * stride + sx * bpp;
        return sum[31:0];
    endfunction

    function automatic lookup_t predict_lookup(logic k, logic [11:0] dx, logic [11:0] dy,
                                               logic [7:0] b, logic [7:0] g, logic [7:0] r);
        lookup_t res;
        res.hdr_ok     = header_good();
        res.src_offset = (k == 1'b0 && res.hdr_ok) ? source_address(dx, dy) : '0;
        res.rgb565     = (k == 1'b1) ? {r[7:3], g[7:2], b[7:3]} : '0;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hdr_magic    = BMP_MAGIC;
            hdr_offset   = BMP_MIN_OFFSET;
            hdr_src_w    = 12'd800;
            hdr_src_h    = 13'd480;
            hdr_depth    = 6'd24;
            hdr_dst_w    = 12'd800;
            hdr_dst_h    = 12'd480;
            lookups_in_flight.delete();
            mismatch_cnt = 0;
            in_flight    = 0;
        end
        else begin
            if (cfg.valid && cfg.ready)
                store_header_reg(cfg.index, cfg.data);
            if (req.valid && req.ready)
                lookups_in_flight.push_back(predict_lookup(req.kind, req.dest_x, req.dest_y,
                    req.blue_byte, req.green_byte, req.red_byte));
            if (rsp.valid && rsp.ready) begin
                got = '{rsp.source_byte_offset, rsp.pixel_rgb565, rsp.header_ok};
                if (lookups_in_flight.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("ERROR: response with no request outstanding: offset %h rgb %h ok %b",
                                 got.src_offset, got.rgb565, got.hdr_ok);
                    mismatch_cnt++;
                end
                else begin
                    want = lookups_in_flight.pop_front();
                    if (got.src_offset !== want.src_offset || got.rgb565 !== want.rgb565 ||
                        got.hdr_ok !== want.hdr_ok) begin
                        if (mismatch_cnt < 10)
                            $display("ERROR: mismatch: offset exp %h got %h, rgb565 exp %h got %h, header_ok exp %b got %b",
                                     want.src_offset, got.src_offset, want.rgb565, got.rgb565,
                                     want.hdr_ok, got.hdr_ok);
                        mismatch_cnt++;
                    end
                end
            end
            in_flight = lookups_in_flight.size();
        end
    end

endmodule

[verif/tb_top.sv]
// Testbench top: clock, reset, header programming, request and response traffic, verdict.
`timescale 1ns / 100ps

module tb_top;
    import bmpsc_pkg::*;

    localparam int COORD_BITS      = 12;
    localparam int RAND_PHASES     = 13;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int CORNER_HEADERS  = 10;
    localparam int CYCLE_LIMIT     = 500000;

    // index with no register behind it; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct {
        logic [15:0] magic;
        logic [31:0] offset;
        logic [11:0] src_w;
        logic [12:0] src_h;
        logic [5:0]  depth;
        logic [11:0] dst_w;
        logic [11:0] dst_h;
    } header_t;

    logic clk;
    logic rst_n;
    int   cycle_cnt;
    int   mismatch_cnt;
    int   in_flight;
    int   send_gap_odds;   // 0: back-to-back requests, else 1-in-N chance of a gap
    int   stall_odds;      // same for response backpressure
    int   stall_left;
    header_t hdr;

    bmpsc_in_if #(.COORD_BITS(COORD_BITS)) req_if ();
    bmpsc_out_if                           rsp_if ();
    bmpsc_cfg_if                           cfg_if ();

    bmp_nearest_scale_rgb565 #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    bmpsc_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_if),
        .rsp          (rsp_if),
        .cfg          (cfg_if),
        .mismatch_cnt (mismatch_cnt),
        .in_flight    (in_flight)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run guard: far above the slowest legal run (every request gapped and
    // every response stalled the longest, plus the drains between phases).
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Response backpressure: random stall bursts, odds set per phase.
    always @(negedge clk) begin
        if (rst_n) begin
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                rsp_if.ready <= 1'b0;
                stall_left   <= $urandom_range(0, 7);
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // Register write. Leaves valid high so back-to-back writes never drop
    // and re-raise it in one step; the caller lowers it after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Junk above the register width now and then; the block must mask it.
    function automatic logic [31:0] with_junk(logic [31:0] val, int width);
        if ($urandom_range(0, 3) == 0)
            return val | ($urandom << width);
        return val;
    endfunction

    // Full header load, ending with a write to the unmapped index.
    task automatic load_header(input header_t h);
        write_reg(REG_MAGIC,       with_junk(32'(h.magic), 16));
        write_reg(REG_DATA_OFFSET, h.offset);
        write_reg(REG_SRC_WIDTH,   with_junk(32'(h.src_w), 12));
        write_reg(REG_SRC_HEIGHT,  with_junk(32'(h.src_h), 13));
        write_reg(REG_BIT_DEPTH,   with_junk(32'(h.depth), 6));
        write_reg(REG_DST_WIDTH,   with_junk(32'(h.dst_w), 12));
        write_reg(REG_DST_HEIGHT,  with_junk(32'(h.dst_h), 12));
        write_reg(REG_NONE,        $urandom);
        cfg_if.valid <= 1'b0;
    endtask

    // One request; valid stays high into the next request unless a gap is drawn.
    task automatic send_req(input logic k, input logic [11:0] x, input logic [11:0] y,
                            input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
        req_if.valid      <= 1'b1;
        req_if.kind       <= k;
        req_if.dest_x     <= x;
        req_if.dest_y     <= y;
        req_if.blue_byte  <= b;
        req_if.green_byte <= g;
        req_if.red_byte   <= r;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        @(negedge clk);
        if (send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(negedge clk);
        end
    endtask

    // Hold off until every outstanding request has answered, then let the
    // pipeline settle before touching the header registers.
    task automatic await_idle();
        while (in_flight != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 2)
            @(negedge clk);
    endtask

    function automatic logic [11:0] pick_size();
        case ($urandom_range(0, 3))
            0:       return 12'($urandom_range(1, 16));
            1:       return 12'd4095;
            default: return 12'($urandom_range(1, 4095));
        endcase
    endfunction

    // Corner headers: size extremes, top-down rows, address wrap, each
    // invalid-header cause, zero destination size, and the -4096 height.
    function automatic header_t corner_header(int n);
        header_t h;
        h = '{BMP_MAGIC, BMP_MIN_OFFSET, 12'd800, 13'd480, 6'd24, 12'd800, 12'd480};
        case (n)
            0: h = '{BMP_MAGIC, 32'd138, 12'd4095, 13'h1001, 6'd32, 12'd1, 12'd1};
            1: h = '{BMP_MAGIC, 32'hFFFF_FFF0, 12'd4095, 13'd4095, 6'd24, 12'd4095, 12'd4095};
            2: h.magic  = 16'h424D;
            3: h.depth  = 6'd16;
            4: h.src_w  = 12'd0;
            5: h.src_h  = 13'd0;
            6: h.offset = BMP_MIN_OFFSET - 1;
            7: h = '{BMP_MAGIC, BMP_MIN_OFFSET, 12'd1, 13'd1, 6'd24, 12'd0, 12'd480};
            8: h = '{BMP_MAGIC, BMP_MIN_OFFSET, 12'd800, 13'd480, 6'd32, 12'd800, 12'd0};
            default: h = '{BMP_MAGIC, 32'd1078, 12'd3, 13'h1000, 6'd24, 12'd3, 12'd7};
        endcase
        return h;
    endfunction

    // Mostly valid headers, with an occasional bad field or zero size.
    function automatic header_t roll_header();
        header_t h;
        logic [11:0] mag;
        h.magic = ($urandom_range(0, 15) == 0) ? 16'($urandom) : BMP_MAGIC;
        case ($urandom_range(0, 9))
            0:       h.offset = $urandom;
            1:       h.offset = 32'($urandom_range(0, 60));
            default: h.offset = 32'($urandom_range(54, 8192));
        endcase
        h.src_w = ($urandom_range(0, 19) == 0) ? 12'd0 : pick_size();
        mag     = pick_size();
        case ($urandom_range(0, 19))
            0:       h.src_h = 13'd0;
            1:       h.src_h = 13'h1000;
            default: h.src_h = $urandom_range(0, 1) ? -{1'b0, mag} : {1'b0, mag};
        endcase
        case ($urandom_range(0, 9))
            0:       h.depth = 6'($urandom);
            default: h.depth = $urandom_range(0, 1) ? 6'd24 : 6'd32;
        endcase
        h.dst_w = ($urandom_range(0, 24) == 0) ? 12'd0 : pick_size();
        h.dst_h = ($urandom_range(0, 24) == 0) ? 12'd0 : pick_size();
        return h;
    endfunction

    // Coordinates mostly inside the destination frame, edges favored,
    // some anywhere in the 12-bit field to hit the clamp.
    function automatic logic [11:0] pick_coord(logic [11:0] lim);
        if (lim == '0 || $urandom_range(0, 9) == 0)
            return 12'($urandom);
        case ($urandom_range(0, 9))
            0:       return 12'd0;
            1:       return lim - 1;
            default: return 12'($urandom_range(0, lim - 1));
        endcase
    endfunction

    task automatic send_random_request(input header_t h);
        send_req($urandom_range(0, 9) < 3, pick_coord(h.dst_w), pick_coord(h.dst_h),
                 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    initial begin
        rst_n             = 1'b0;
        cycle_cnt         = 0;
        stall_left        = 0;
        stall_odds        = 4;
        send_gap_odds     = 3;
        req_if.valid      = 1'b0;
        req_if.kind       = 1'b0;
        req_if.dest_x     = '0;
        req_if.dest_y     = '0;
        req_if.blue_byte  = '0;
        req_if.green_byte = '0;
        req_if.red_byte   = '0;
        rsp_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = '0;
        cfg_if.data       = '0;

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset header, frame corners, just past the frame, and
        // the color pack at all-ones and with only truncated bits set.
        send_req(1'b0, 12'd0,   12'd0,   8'h00, 8'h00, 8'h00);
        send_req(1'b0, 12'd799, 12'd479, 8'hFF, 8'hFF, 8'hFF);
        send_req(1'b0, 12'd800, 12'd480, 8'h00, 8'h00, 8'h00);
        send_req(1'b1, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF);
        send_req(1'b1, 12'd0,   12'd0,   8'h07, 8'h03, 8'h07);
        req_if.valid <= 1'b0;

        for (int n = 0; n < CORNER_HEADERS; n++) begin
            await_idle();
            load_header(corner_header(n));
            send_req(1'b0, 12'd0,   12'd0,   8'($urandom), 8'($urandom), 8'($urandom));
            send_req(1'b0, 12'hFFF, 12'hFFF, 8'($urandom), 8'($urandom), 8'($urandom));
            req_if.valid <= 1'b0;
        end

        // Random phases, each behind a fresh header. Idling odds change per
        // phase, sometimes to none; the last phase runs with no idling at all.
        for (int p = 0; p < RAND_PHASES; p++) begin
            await_idle();
            hdr = roll_header();
            load_header(hdr);
            if (p == RAND_PHASES - 1) begin
                send_gap_odds = 0;
                stall_odds    = 0;
            end
            else begin
                send_gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
                stall_odds    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_random_request(hdr);
            req_if.valid <= 1'b0;
        end

        await_idle();
        if (mismatch_cnt == 0 && in_flight == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
